>>> src/ost_pkg.sv
// Shared types and constants for the owned slot table.
// No dependencies; imported by every module of the block except the RAM.
`default_nettype none

package ost_pkg;

    // Field widths of the request and result items
    localparam int SLOT_W  = 8;
    localparam int ACT_W   = 3;
    localparam int COUNT_W = 7;
    localparam int CFG_W   = 7;

    // Stream payload widths, padded to whole bytes
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 16;

    // Defaults and reset values
    localparam int               SLOT_COUNT_DEF   = 64;
    localparam logic [CFG_W-1:0] SLOTS_IN_USE_RST = 7'd64;

    // Slot number that means "none" / "any"
    localparam logic [SLOT_W-1:0] NONE_SLOT = 8'hFF;
    localparam logic [SLOT_W-1:0] FREE_TYPE = 8'h00;

    // Request actions (code 7 is a no-op)
    typedef enum logic [ACT_W-1:0] {
        ACT_FREE        = 3'd0,
        ACT_FIND        = 3'd1,
        ACT_COUNT_TYPE  = 3'd2,
        ACT_COUNT_OWNED = 3'd3,
        ACT_FIRST_FREE  = 3'd4,
        ACT_SAVE        = 3'd5,
        ACT_CLEAR       = 3'd6
    } action_t;

    // One request as held during its sweep
    typedef struct packed {
        logic [SLOT_W-1:0] owner;
        logic [SLOT_W-1:0] item_type;
        logic [SLOT_W-1:0] slot;
        action_t           action;
    } req_t;

endpackage

`default_nettype wire

>>> src/owned_slot_table.sv
// Owned slot table top level: stream ports, sweep sequencer, slot storage.
// Depends on ost_pkg, ost_ram, ost_match.
//
//  channel  | ports                           | carries
//  ---------+---------------------------------+---------------------------------------
//  request  | s_tvalid s_tready s_tdata[31:0] | action, slot, item_type, owner
//  result   | m_tvalid m_tready m_tdata[15:0] | found_slot, item_count
//  config   | cfg_valid cfg_ready cfg_data    | slots_in_use (always ready)
//
// One request at a time. Save, clear, no-op and free of a slot outside the table
// go straight to the response state, then to the result register. Find, counts and
// first free sweep the active slots through the RAM read ports and the compare unit.
// A free cascade repeats the sweep until one changes nothing.
// Reset is synchronous; slot storage reads as empty after reset via per-slot valid bits.
// A stalled result holds the block in its response state until taken.
`default_nettype none

module owned_slot_table #(
    parameter int SLOT_COUNT = ost_pkg::SLOT_COUNT_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // request: [2:0] action, [10:3] slot, [18:11] item_type, [26:19] owner
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [ost_pkg::S_DATA_W-1:0]   s_tdata,
    // result: [7:0] found_slot, [14:8] item_count
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic      [ost_pkg::M_DATA_W-1:0]   m_tdata,
    // slots_in_use register write
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [ost_pkg::CFG_W-1:0]      cfg_data
);
    import ost_pkg::*;

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W = $clog2(SLOT_COUNT + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESP
    } state_t;

    state_t             state_reg, state_next;
    req_t               req_reg, req_next;
    logic [CFG_W-1:0]   slots_in_use_reg, slots_in_use_next;
    logic [CNT_W-1:0]   active_reg, active_next;
    logic [CNT_W-1:0]   issue_idx_reg, issue_idx_next;
    logic               data_vld_reg, data_vld_next;
    logic [IDX_W-1:0]   data_idx_reg, data_idx_next;
    logic               ent_valid_reg, ent_valid_next;
    logic               changed_reg, changed_next;
    logic [SLOT_W-1:0]  found_reg, found_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [SLOT_COUNT-1:0] valid_reg, valid_next;
    logic [SLOT_COUNT-1:0] mark_reg, mark_next;
    logic               out_valid_reg, out_valid_next;
    logic [SLOT_W-1:0]  out_found_reg, out_found_next;
    logic [COUNT_W-1:0] out_count_reg, out_count_next;

    req_t               s_req;
    logic               s_fire;
    logic               slot_in_tbl;
    logic [IDX_W-1:0]   s_idx;
    logic [CNT_W-1:0]   act_cur;

    logic               type_we;
    logic [IDX_W-1:0]   type_waddr;
    logic [SLOT_W-1:0]  type_wdata;
    logic               own_we;
    logic [SLOT_W-1:0]  type_rdata;
    logic [SLOT_W-1:0]  own_rdata;
    logic [SLOT_W-1:0]  ent_type;
    logic [SLOT_W-1:0]  ent_owner;
    logic               hit;

    // request unpack
    assign s_req.action    = action_t'(s_tdata[2:0]);
    assign s_req.slot      = s_tdata[10:3];
    assign s_req.item_type = s_tdata[18:11];
    assign s_req.owner     = s_tdata[26:19];

    assign s_tready  = state_reg == ST_IDLE;
    assign s_fire    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_count_reg, out_found_reg};

    assign slot_in_tbl = s_req.slot < SLOT_W'(SLOT_COUNT);
    assign s_idx       = s_req.slot[IDX_W-1:0];
    assign act_cur     = (SLOT_W'(slots_in_use_reg) > SLOT_W'(SLOT_COUNT)) ?
                         CNT_W'(SLOT_COUNT) : CNT_W'(slots_in_use_reg);

    // slot storage: type and owner in separate RAMs
    ost_ram #(.WIDTH(SLOT_W), .DEPTH(SLOT_COUNT)) u_type_ram (
        .aclk  (aclk),
        .we    (type_we),
        .waddr (type_waddr),
        .wdata (type_wdata),
        .raddr (issue_idx_reg[IDX_W-1:0]),
        .rdata (type_rdata)
    );

    ost_ram #(.WIDTH(SLOT_W), .DEPTH(SLOT_COUNT)) u_owner_ram (
        .aclk  (aclk),
        .we    (own_we),
        .waddr (s_idx),
        .wdata (s_req.owner),
        .raddr (issue_idx_reg[IDX_W-1:0]),
        .rdata (own_rdata)
    );

    // never-written slots read as empty
    assign ent_type  = ent_valid_reg ? type_rdata : FREE_TYPE;
    assign ent_owner = ent_valid_reg ? own_rdata  : '0;

    ost_match #(.SLOT_COUNT(SLOT_COUNT)) u_match (
        .req       (req_reg),
        .ent_type  (ent_type),
        .ent_owner (ent_owner),
        .marks     (mark_reg),
        .hit       (hit)
    );

    // sequencer next state
    always_comb begin
        state_next        = state_reg;
        req_next          = req_reg;
        slots_in_use_next = slots_in_use_reg;
        active_next       = active_reg;
        issue_idx_next    = issue_idx_reg;
        data_vld_next     = data_vld_reg;
        data_idx_next     = data_idx_reg;
        ent_valid_next    = ent_valid_reg;
        changed_next      = changed_reg;
        found_next        = found_reg;
        count_next        = count_reg;
        valid_next        = valid_reg;
        mark_next         = mark_reg;
        out_valid_next    = out_valid_reg;
        out_found_next    = out_found_reg;
        out_count_next    = out_count_reg;
        type_we           = 1'b0;
        type_waddr        = s_idx;
        type_wdata        = s_req.item_type;
        own_we            = 1'b0;

        if (cfg_valid) begin
            slots_in_use_next = cfg_data;
        end

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    req_next       = s_req;
                    active_next    = act_cur;
                    found_next     = NONE_SLOT;
                    count_next     = '0;
                    issue_idx_next = '0;
                    data_vld_next  = 1'b0;
                    changed_next   = 1'b0;
                    state_next     = ST_RESP;
                    unique case (s_req.action)
                        ACT_FREE: begin
                            mark_next = '0;
                            if (slot_in_tbl) begin
                                type_we          = 1'b1;
                                type_wdata       = FREE_TYPE;
                                mark_next[s_idx] = 1'b1;
                                state_next       = ST_SCAN;
                            end
                        end
                        ACT_FIND: begin
                            if (s_req.slot < SLOT_W'(act_cur)) begin
                                issue_idx_next = CNT_W'(s_req.slot);
                                state_next     = ST_SCAN;
                            end
                        end
                        ACT_COUNT_TYPE, ACT_COUNT_OWNED, ACT_FIRST_FREE: begin
                            state_next = ST_SCAN;
                        end
                        ACT_SAVE: begin
                            if (slot_in_tbl) begin
                                type_we           = 1'b1;
                                own_we            = 1'b1;
                                valid_next[s_idx] = 1'b1;
                            end
                        end
                        ACT_CLEAR: begin
                            valid_next = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            ST_SCAN: begin
                // issue the next read
                if (issue_idx_reg < active_reg) begin
                    data_vld_next  = 1'b1;
                    data_idx_next  = issue_idx_reg[IDX_W-1:0];
                    ent_valid_next = valid_reg[issue_idx_reg[IDX_W-1:0]];
                    issue_idx_next = issue_idx_reg + 1'b1;
                end else begin
                    data_vld_next = 1'b0;
                end

                // evaluate the entry read last cycle
                if (data_vld_reg) begin
                    if (hit) begin
                        priority case (req_reg.action)
                            ACT_FREE: begin
                                type_we                 = 1'b1;
                                type_waddr              = data_idx_reg;
                                type_wdata              = FREE_TYPE;
                                mark_next[data_idx_reg] = 1'b1;
                                changed_next            = 1'b1;
                            end
                            ACT_FIND, ACT_FIRST_FREE: begin
                                found_next    = SLOT_W'(data_idx_reg);
                                data_vld_next = 1'b0;
                                state_next    = ST_RESP;
                            end
                            default: begin
                                count_next = count_reg + 1'b1;
                            end
                        endcase
                    end
                end else if (issue_idx_reg >= active_reg) begin
                    // sweep drained: repeat a cascade that changed something
                    if (req_reg.action == ACT_FREE && changed_reg) begin
                        issue_idx_next = '0;
                        changed_next   = 1'b0;
                    end else begin
                        state_next = ST_RESP;
                    end
                end
            end

            ST_RESP: begin
                if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    out_found_next = found_reg;
                    out_count_next = COUNT_W'(count_reg);
                    state_next     = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            slots_in_use_reg <= SLOTS_IN_USE_RST;
            data_vld_reg     <= 1'b0;
            changed_reg      <= 1'b0;
            valid_reg        <= '0;
            mark_reg         <= '0;
            out_valid_reg    <= 1'b0;
            issue_idx_reg    <= '0;
            active_reg       <= '0;
        end else begin
            state_reg        <= state_next;
            slots_in_use_reg <= slots_in_use_next;
            data_vld_reg     <= data_vld_next;
            changed_reg      <= changed_next;
            valid_reg        <= valid_next;
            mark_reg         <= mark_next;
            out_valid_reg    <= out_valid_next;
            issue_idx_reg    <= issue_idx_next;
            active_reg       <= active_next;
        end
        req_reg       <= req_next;
        data_idx_reg  <= data_idx_next;
        ent_valid_reg <= ent_valid_next;
        found_reg     <= found_next;
        count_reg     <= count_next;
        out_found_reg <= out_found_next;
        out_count_reg <= out_count_next;
    end

    // read pointer never runs past the active slots
    a_issue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SCAN |-> issue_idx_reg <= active_reg)
        else $error("read pointer past active slots");

    // an entry under evaluation is an active slot
    a_data_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN && data_vld_reg) |-> CNT_W'(data_idx_reg) < active_reg)
        else $error("evaluated slot outside active range");

    // a found slot is either none or an active slot
    a_found: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_RESP |-> (found_reg == NONE_SLOT || found_reg < SLOT_W'(active_reg)))
        else $error("found slot outside active range");

    // counts never exceed the slots swept
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_IDLE |-> count_reg <= active_reg)
        else $error("count exceeds active slots");

    // storage is written during a sweep only by the cascade on a hit
    a_scan_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN && type_we) |-> (data_vld_reg && req_reg.action == ACT_FREE && !own_we))
        else $error("unexpected slot write during sweep");

endmodule

`default_nettype wire

>>> src/ost_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module ost_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> src/ost_match.sv
// Shared compare unit: decides whether one slot entry hits the current request.
// Depends on ost_pkg.
`default_nettype none

module ost_match #(
    parameter int SLOT_COUNT = ost_pkg::SLOT_COUNT_DEF
) (
    input  wire ost_pkg::req_t                 req,
    input  wire logic [ost_pkg::SLOT_W-1:0]    ent_type,
    input  wire logic [ost_pkg::SLOT_W-1:0]    ent_owner,
    input  wire logic [SLOT_COUNT-1:0]         marks,
    output logic                               hit
);
    import ost_pkg::*;

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    logic own_in_tbl;
    logic owner_marked;
    logic occupied;

    // owner is a freed slot of the current cascade
    assign own_in_tbl   = ent_owner < SLOT_W'(SLOT_COUNT);
    assign owner_marked = own_in_tbl && marks[ent_owner[IDX_W-1:0]];
    assign occupied     = ent_type != FREE_TYPE;

    always_comb begin
        unique case (req.action)
            ACT_FREE:        hit = occupied && owner_marked;
            ACT_FIND:        hit = (ent_type == req.item_type) &&
                                   ((req.owner == NONE_SLOT) || (ent_owner == req.owner));
            ACT_COUNT_TYPE:  hit = (req.item_type == FREE_TYPE) || (ent_type == req.item_type);
            ACT_COUNT_OWNED: hit = occupied && (ent_owner == req.owner);
            ACT_FIRST_FREE:  hit = !occupied;
            default:         hit = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

>>> test/owned_slot_table_checker.sv
// Scoreboard for the owned slot table: watches the request, result and config channels,
// keeps its own copy of the slot table and compares every result in order.
// Depends on ost_pkg.

module owned_slot_table_checker #(
    parameter int SLOT_COUNT = ost_pkg::SLOT_COUNT_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // request: [2:0] action, [10:3] slot, [18:11] item_type, [26:19] owner
    input  logic                         s_tvalid,
    input  logic                         s_tready,
    input  logic [ost_pkg::S_DATA_W-1:0] s_tdata,
    // result: [7:0] found_slot, [14:8] item_count
    input  logic                         m_tvalid,
    input  logic                         m_tready,
    input  logic [ost_pkg::M_DATA_W-1:0] m_tdata,
    input  logic                         cfg_valid,
    input  logic                         cfg_ready,
    input  logic [ost_pkg::CFG_W-1:0]    cfg_data,
    output int unsigned                  error_total,
    output int unsigned                  outstanding
);
    import ost_pkg::*;

    typedef struct packed {
        logic [COUNT_W-1:0] item_count;
        logic [SLOT_W-1:0]  found_slot;
    } table_answer_t;

    // Shadow of the slot storage and the active-slot register
    logic [SLOT_W-1:0] slot_kind  [SLOT_COUNT];
    logic [SLOT_W-1:0] slot_owner [SLOT_COUNT];
    bit                freed_mark [SLOT_COUNT];
    logic [CFG_W-1:0]  slots_in_use;

    table_answer_t table_answers [$];
    table_answer_t predicted;
    table_answer_t oldest;
    int unsigned   mismatches = 0;

    assign error_total = mismatches;

    // Apply one request to the shadow table and work out its result
    task automatic apply_table_request(input req_t req, output table_answer_t ans);
        int unsigned active;
        int unsigned tally;
        int unsigned i;
        bit          changed;
        logic [SLOT_W-1:0] own;
        active = (slots_in_use > SLOT_COUNT) ? SLOT_COUNT : slots_in_use;
        tally  = 0;
        ans.found_slot = NONE_SLOT;
        case (req.action)
            ACT_FREE: begin
                foreach (freed_mark[k]) freed_mark[k] = 1'b0;
                if (req.slot < SLOT_COUNT) begin
                    slot_kind[req.slot]  = FREE_TYPE;
                    freed_mark[req.slot] = 1'b1;
                    // sweep until a pass frees nothing new
                    changed = 1'b1;
                    while (changed) begin
                        changed = 1'b0;
                        for (i = 0; i < active; i++) begin
                            own = slot_owner[i];
                            if (slot_kind[i] != FREE_TYPE && own < SLOT_COUNT
                                    && freed_mark[own]) begin
                                slot_kind[i]  = FREE_TYPE;
                                freed_mark[i] = 1'b1;
                                changed       = 1'b1;
                            end
                        end
                    end
                end
            end
            ACT_FIND: begin
                for (i = req.slot; i < active; i++) begin
                    if (slot_kind[i] == req.item_type
                            && (req.owner == NONE_SLOT || slot_owner[i] == req.owner)) begin
                        ans.found_slot = SLOT_W'(i);
                        break;
                    end
                end
            end
            ACT_COUNT_TYPE: begin
                for (i = 0; i < active; i++)
                    if (req.item_type == FREE_TYPE || slot_kind[i] == req.item_type)
                        tally++;
            end
            ACT_COUNT_OWNED: begin
                for (i = 0; i < active; i++)
                    if (slot_kind[i] != FREE_TYPE && slot_owner[i] == req.owner)
                        tally++;
            end
            ACT_FIRST_FREE: begin
                for (i = 0; i < active; i++) begin
                    if (slot_kind[i] == FREE_TYPE) begin
                        ans.found_slot = SLOT_W'(i);
                        break;
                    end
                end
            end
            ACT_SAVE: begin
                if (req.slot < SLOT_COUNT) begin
                    slot_kind[req.slot]  = req.item_type;
                    slot_owner[req.slot] = req.owner;
                end
            end
            ACT_CLEAR: begin
                foreach (slot_kind[k]) begin
                    slot_kind[k]  = FREE_TYPE;
                    slot_owner[k] = '0;
                end
            end
            default: ;  // no-op code
        endcase
        ans.item_count = COUNT_W'(tally);
    endtask

    // Track handshakes: config first, then the new request, then the result taken
    always @(posedge aclk) begin
        if (!aresetn) begin
            foreach (slot_kind[k]) begin
                slot_kind[k]  = FREE_TYPE;
                slot_owner[k] = '0;
                freed_mark[k] = 1'b0;
            end
            slots_in_use = SLOTS_IN_USE_RST;
            table_answers.delete();
        end else begin
            if (cfg_valid && cfg_ready)
                slots_in_use = cfg_data;

            if (s_tvalid && s_tready) begin
                apply_table_request(req_t'(s_tdata[$bits(req_t)-1:0]), predicted);
                table_answers.push_back(predicted);
            end

            if (m_tvalid && m_tready) begin
                if (table_answers.size() == 0) begin
                    $error("unexpected result: found_slot %0d, item_count %0d",
                           m_tdata[7:0], m_tdata[14:8]);
                    mismatches++;
                end else begin
                    oldest = table_answers.pop_front();
                    if (m_tdata[7:0] !== oldest.found_slot) begin
                        $error("found_slot mismatch: expected %0d, actual %0d",
                               oldest.found_slot, m_tdata[7:0]);
                        mismatches++;
                    end
                    if (m_tdata[14:8] !== oldest.item_count) begin
                        $error("item_count mismatch: expected %0d, actual %0d",
                               oldest.item_count, m_tdata[14:8]);
                        mismatches++;
                    end
                end
            end
        end
        outstanding <= table_answers.size();
    end

endmodule

>>> test/owned_slot_table_tb.sv
// Testbench top for the owned slot table: clock, reset, request and config stimulus,
// result back-pressure and the verdict. Depends on ost_pkg, owned_slot_table and
// owned_slot_table_checker.

module owned_slot_table_tb;
    import ost_pkg::*;

    localparam int      TABLE_SLOTS = SLOT_COUNT_DEF;
    localparam action_t ACT_NOP     = action_t'(3'd7);

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata   = '0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [CFG_W-1:0]    cfg_data  = '0;

    int unsigned error_total;
    int unsigned outstanding;

    // stimulus shaping
    int unsigned active_hint = TABLE_SLOTS;
    bit          steady      = 1'b0;
    int unsigned sink_hold   = 0;
    int unsigned sink_roll;

    owned_slot_table #(.SLOT_COUNT(TABLE_SLOTS)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    owned_slot_table_checker #(.SLOT_COUNT(TABLE_SLOTS)) u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .error_total(error_total),
        .outstanding(outstanding)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Result back-pressure: short stalls mostly, a few long ones, none in steady mode
    always @(posedge aclk) begin
        if (steady) begin
            m_tready  <= 1'b1;
            sink_hold <= 0;
        end else if (sink_hold != 0) begin
            sink_hold <= sink_hold - 1;
        end else begin
            sink_roll = $urandom_range(0, 99);
            if (m_tready) begin
                m_tready  <= 1'b0;
                sink_hold <= (sink_roll < 85) ? $urandom_range(0, 3) : $urandom_range(15, 120);
            end else begin
                m_tready  <= 1'b1;
                sink_hold <= $urandom_range(0, 30);
            end
        end
    end

    function automatic req_t make_request(input action_t act, input logic [7:0] slot,
                                          input logic [7:0] kind, input logic [7:0] owner);
        req_t req;
        req.action    = act;
        req.slot      = slot;
        req.item_type = kind;
        req.owner     = owner;
        return req;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (steady || roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 60);
    endfunction

    // Slot numbers cluster around the active region so trees form and get searched
    function automatic logic [7:0] pick_slot(input int unsigned lim);
        if ($urandom_range(0, 9) == 0)
            return 8'($urandom_range(0, 255));
        return 8'($urandom_range(0, lim));
    endfunction

    function automatic logic [7:0] pick_owner(input int unsigned lim);
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (roll < 2)
            return NONE_SLOT;
        if (roll < 9)
            return 8'($urandom_range(0, lim));
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] pick_kind();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 75)
            return 8'($urandom_range(1, 4));
        if (roll < 85)
            return FREE_TYPE;
        return 8'($urandom_range(0, 255));
    endfunction

    // Mostly table-building saves, lookups and cascades; some raw noise
    function automatic req_t random_request();
        req_t        req;
        int unsigned roll;
        int unsigned lim;
        lim  = (active_hint < 4) ? 7 : ((active_hint + 3 > 63) ? 63 : active_hint + 3);
        roll = $urandom_range(0, 99);
        req  = make_request(ACT_SAVE, pick_slot(lim), pick_kind(), pick_owner(lim));
        if (roll < 12) begin
            req = make_request(action_t'(3'($urandom_range(0, 7))),
                               8'($urandom_range(0, 255)),
                               8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        end else if (roll < 42) begin
            req.action = ACT_SAVE;
        end else if (roll < 54) begin
            req.action = ACT_FIND;
            if ($urandom_range(0, 1) == 0)
                req.owner = NONE_SLOT;
        end else if (roll < 62) begin
            req.action = ACT_COUNT_TYPE;
        end else if (roll < 70) begin
            req.action = ACT_COUNT_OWNED;
        end else if (roll < 78) begin
            req.action = ACT_FIRST_FREE;
        end else if (roll < 95) begin
            req.action = ACT_FREE;
        end else if (roll < 97) begin
            req.action = ACT_CLEAR;
        end else begin
            req.action = ACT_NOP;
        end
        return req;
    endfunction

    // Present one request after a random gap and hold it until accepted
    task automatic send_request(input req_t req);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_DATA_W'(req);
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic wait_until_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    // Register writes happen only with the table idle
    task automatic write_slots_in_use(input logic [CFG_W-1:0] value);
        wait_until_drained();
        repeat (4) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid   <= 1'b0;
        active_hint = (value > TABLE_SLOTS) ? TABLE_SLOTS : value;
    endtask

    initial begin
        logic [CFG_W-1:0] phase_setting [6];
        phase_setting[0] = 7'd127;
        phase_setting[1] = 7'd1;
        phase_setting[2] = 7'd0;
        phase_setting[3] = 7'd64;
        phase_setting[4] = CFG_W'($urandom_range(2, 63));
        phase_setting[5] = CFG_W'($urandom_range(0, 127));

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: field extremes, every action, a multi-sweep cascade
        send_request(make_request(ACT_FIRST_FREE, 0, 0, 0));
        send_request(make_request(ACT_COUNT_TYPE, 0, FREE_TYPE, 0));
        send_request(make_request(ACT_SAVE, 0, 255, NONE_SLOT));
        send_request(make_request(ACT_SAVE, 63, 1, 0));
        send_request(make_request(ACT_SAVE, 5, 2, 63));
        send_request(make_request(ACT_SAVE, 64, 7, 0));
        send_request(make_request(ACT_SAVE, 255, 9, 1));
        send_request(make_request(ACT_FIND, 0, 255, NONE_SLOT));
        send_request(make_request(ACT_FIND, 1, FREE_TYPE, NONE_SLOT));
        send_request(make_request(ACT_FIND, 0, 2, 63));
        send_request(make_request(ACT_FIND, 200, 1, NONE_SLOT));
        send_request(make_request(ACT_COUNT_TYPE, 0, 1, 0));
        send_request(make_request(ACT_COUNT_OWNED, 0, 0, 0));
        send_request(make_request(ACT_COUNT_OWNED, 0, 0, NONE_SLOT));
        send_request(make_request(ACT_FIRST_FREE, 0, 0, 0));
        // some owners sit above their children, so the cascade needs several sweeps
        send_request(make_request(ACT_SAVE, 10, 3, 5));
        send_request(make_request(ACT_SAVE, 2, 4, 10));
        send_request(make_request(ACT_FREE, 0, 0, 0));
        send_request(make_request(ACT_COUNT_OWNED, 0, 0, 5));
        send_request(make_request(ACT_FREE, 255, 0, 0));
        send_request(make_request(ACT_NOP, 255, 255, 255));
        send_request(make_request(ACT_SAVE, 30, 8, 200));
        send_request(make_request(ACT_CLEAR, 0, 0, 0));
        send_request(make_request(ACT_COUNT_TYPE, 0, 8, 0));
        send_request(make_request(ACT_FIND, 0, FREE_TYPE, 0));

        // Random phases, one per active-slot setting
        foreach (phase_setting[p]) begin
            write_slots_in_use(phase_setting[p]);
            steady = (p == 3);
            repeat (96) send_request(random_request());
        end

        wait_until_drained();
        repeat (100) @(posedge aclk);
        if (error_total == 0 && outstanding == 0) begin
            $display("owned_slot_table_tb: clean");
        end else begin
            $display("owned_slot_table_tb: errors");
        end
        $finish;
    end

    // Hang guard
    initial begin
        #200000000;
        $display("owned_slot_table_tb: errors");
        $finish;
    end

endmodule
